>>> rtl/core/psls_pkg.sv
// Shared constants for the polygon scan line sequencer: field widths,
// opcodes, laser actions, scan phases, register indexes and reset values.
// No dependencies.
`default_nettype none

package psls_pkg;

  localparam int PERIOD_W = 16;
  localparam int PCT_W = 8;
  localparam int PROD_W = PERIOD_W + PCT_W;
  localparam int OP_W = 2;
  localparam int ACT_W = 3;
  localparam int PHASE_W = 3;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  localparam int PCT_DIVISOR = 100;
  localparam int PCT_DIV_W = 7;
  localparam int FILTER_DEPTH_DEF = 8;

  localparam logic [OP_W-1:0] OP_CAPTURE = 2'd0;
  localparam logic [OP_W-1:0] OP_COMPARE = 2'd1;
  localparam logic [OP_W-1:0] OP_SWAP = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FORCE_ON = 3'd1;
  localparam logic [ACT_W-1:0] ACT_OFF = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LINE_START = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LINE_END = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SYNC_ON = 3'd5;

  localparam logic [PHASE_W-1:0] PH_LASER_OFF = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LINE_START = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LINE_END = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SYNC_ON = 3'd3;
  localparam logic [PHASE_W-1:0] PH_FINAL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_LASER_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_LINE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_LINE_END = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_SYNC_ON = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PCT_FINAL = 3'd5;

  localparam logic [PERIOD_W-1:0] RST_SLOW_LIMIT = 16'hFFFF;
  localparam logic [PCT_W-1:0] RST_PCT_LASER_OFF = 8'd2;
  localparam logic [PCT_W-1:0] RST_PCT_LINE_START = 8'd6;
  localparam logic [PCT_W-1:0] RST_PCT_LINE_END = 8'd50;
  localparam logic [PCT_W-1:0] RST_PCT_SYNC_ON = 8'd65;
  localparam logic [PCT_W-1:0] RST_PCT_FINAL = 8'd110;

endpackage

`default_nettype wire

>>> rtl/core/psls_ring.sv
// Period ring of the moving-average filter: one write and one registered read
// per cycle, with a valid bit per entry so that unwritten entries read as zero.
// No dependencies.
`default_nettype none

module psls_ring #(
  parameter int DEPTH = 8,
  parameter int DATA_W = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rd_raw;
  logic              rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

`default_nettype wire

>>> rtl/core/psls_serial_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// No dependencies.
`default_nettype none

module psls_serial_mul #(
  parameter int A_W = 16,
  parameter int B_W = 8,
  localparam int P_W = A_W + B_W,
  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [A_W-1:0] a,
  input  wire logic [B_W-1:0] b,
  output logic                done,
  output logic      [P_W-1:0] product
);

  logic [P_W-1:0]   mcand;
  logic [B_W-1:0]   mplier;
  logic [P_W-1:0]   acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= P_W'(a);
      mplier <= b;
      acc <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[P_W-2:0], 1'b0};
      mplier <= mplier >> 1;
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

>>> rtl/core/psls_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, shared by the
// average and the percent scaling. No dependencies.
`default_nettype none

module psls_serial_div #(
  parameter int WIDTH = 24,
  parameter int DVS_W = 7,
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient
);

  logic [WIDTH-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff = shifted - {1'b0, dvs};
    fits = ~diff[DVS_W];
    rem_next = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[WIDTH-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> rtl/core/polygon_scan_line_sequencer.sv
// Top level of the polygon scan line sequencer: command decode, phase sequencer,
// running filter sum and result register. Uses psls_pkg, psls_ring,
// psls_serial_mul and psls_serial_div.
//
//   channel   direction  handshake           payload
//   cmd       in         cmd_valid/ready     opcode, captured_period, vertical_row_zero
//   res       out        res_valid/ready     compare_time .. modulation_on
//   cfg       in         cfg_we              cfg_index, cfg_data
//
// A capture runs the shared bit-serial divider once for the average and once for the
// percent scaling, and the multiplier works through the percent one bit at a time. A
// compare match runs only the multiply and the percent division, a forced-on or past-end
// compare neither, a forced-on capture only the average division, and a swap request or
// unused opcode goes straight to the result. cmd_ready rises with res_valid as each result
// is registered. Reset clears the ring valid bits at once, so no clearing pass is needed.
// A stalled result sits in the output register while the next command runs.
`default_nettype none

module polygon_scan_line_sequencer #(
  parameter int FILTER_DEPTH = psls_pkg::FILTER_DEPTH_DEF,
  localparam int PTR_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  output logic                                cmd_ready,
  input  wire logic [psls_pkg::OP_W-1:0]      opcode,
  input  wire logic [psls_pkg::PERIOD_W-1:0]  captured_period,
  input  wire logic                           vertical_row_zero,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic      [psls_pkg::PERIOD_W-1:0]  compare_time,
  output logic                                compare_load,
  output logic      [psls_pkg::ACT_W-1:0]     laser_action,
  output logic                                buffer_swap,
  output logic      [psls_pkg::PERIOD_W-1:0]  filtered_period,
  output logic                                modulation_on,
  input  wire logic                           cfg_we,
  input  wire logic [psls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [psls_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SUM_W = psls_pkg::PERIOD_W + $clog2(FILTER_DEPTH);
  localparam int DIV_W = (SUM_W > psls_pkg::PROD_W) ? SUM_W : psls_pkg::PROD_W;
  localparam int DEPTH_BITS = $clog2(FILTER_DEPTH + 1);
  localparam int DVS_W = (DEPTH_BITS > psls_pkg::PCT_DIV_W) ? DEPTH_BITS
                                                            : psls_pkg::PCT_DIV_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_AVG = 3'd2;
  localparam logic [2:0] ST_SEQ = 3'd3;
  localparam logic [2:0] ST_MUL = 3'd4;
  localparam logic [2:0] ST_QUO = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state;

  logic [psls_pkg::PERIOD_W-1:0] slow_period_limit;
  logic [psls_pkg::PCT_W-1:0]    pct_laser_off;
  logic [psls_pkg::PCT_W-1:0]    pct_line_start;
  logic [psls_pkg::PCT_W-1:0]    pct_line_end;
  logic [psls_pkg::PCT_W-1:0]    pct_sync_on;
  logic [psls_pkg::PCT_W-1:0]    pct_final;

  logic [psls_pkg::PHASE_W-1:0]  scan_phase;
  logic                          laser_forced_on;
  logic [psls_pkg::PERIOD_W-1:0] last_period;
  logic                          swap_pending;
  logic [PTR_W-1:0]              ring_pointer;
  logic [PTR_W-1:0]              ring_pointer_next;
  logic [SUM_W-1:0]              ring_sum;
  logic [SUM_W:0]                ring_sum_next;
  logic [psls_pkg::PERIOD_W-1:0] average;

  logic [psls_pkg::PERIOD_W-1:0] cur_period;
  logic                          cur_row_zero;

  logic [psls_pkg::PERIOD_W-1:0] work_time;
  logic                          work_load;
  logic [psls_pkg::ACT_W-1:0]    work_action;
  logic                          work_swap;

  logic                          cmd_accept;
  logic [psls_pkg::PERIOD_W-1:0] ring_rd_data;
  logic [psls_pkg::PCT_W-1:0]    phase_pct;
  logic [psls_pkg::ACT_W-1:0]    phase_action;
  logic                          mul_start;
  logic                          mul_done;
  logic [psls_pkg::PROD_W-1:0]   mul_product;
  logic                          div_start;
  logic                          div_done;
  logic [DIV_W-1:0]              div_dividend;
  logic [DVS_W-1:0]              div_divisor;
  logic [DIV_W-1:0]              div_quotient;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_accept = cmd_valid && cmd_ready;

  always_comb begin
    if (ring_pointer == PTR_W'(FILTER_DEPTH - 1)) begin
      ring_pointer_next = '0;
    end else begin
      ring_pointer_next = ring_pointer + PTR_W'(1);
    end
    ring_sum_next = {1'b0, ring_sum} + (SUM_W + 1)'(cur_period)
                    - (SUM_W + 1)'(ring_rd_data);
  end

  always_comb begin
    unique case (scan_phase)
      psls_pkg::PH_LASER_OFF: begin
        phase_pct = pct_laser_off;
        phase_action = psls_pkg::ACT_NONE;
      end
      psls_pkg::PH_LINE_START: begin
        phase_pct = pct_line_start;
        phase_action = psls_pkg::ACT_OFF;
      end
      psls_pkg::PH_LINE_END: begin
        phase_pct = pct_line_end;
        phase_action = psls_pkg::ACT_LINE_START;
      end
      psls_pkg::PH_SYNC_ON: begin
        phase_pct = pct_sync_on;
        phase_action = psls_pkg::ACT_LINE_END;
      end
      psls_pkg::PH_FINAL: begin
        phase_pct = pct_final;
        phase_action = psls_pkg::ACT_SYNC_ON;
      end
      default: begin
        phase_pct = '0;
        phase_action = psls_pkg::ACT_NONE;
      end
    endcase
  end

  assign mul_start = (state == ST_SEQ) && !laser_forced_on
                     && (scan_phase <= psls_pkg::PH_FINAL);
  assign div_start = (state == ST_READ) || ((state == ST_MUL) && mul_done);

  always_comb begin
    if (state == ST_READ) begin
      div_dividend = DIV_W'(ring_sum_next[SUM_W-1:0]);
      div_divisor = DVS_W'(FILTER_DEPTH);
    end else begin
      div_dividend = DIV_W'(mul_product);
      div_divisor = DVS_W'(psls_pkg::PCT_DIVISOR);
    end
  end

  psls_ring #(
    .DEPTH  (FILTER_DEPTH),
    .DATA_W (psls_pkg::PERIOD_W)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd_accept),
    .rd_addr (ring_pointer_next),
    .rd_data (ring_rd_data),
    .wr_en   (state == ST_READ),
    .wr_addr (ring_pointer),
    .wr_data (cur_period)
  );

  psls_serial_mul #(
    .A_W (psls_pkg::PERIOD_W),
    .B_W (psls_pkg::PCT_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (last_period),
    .b       (phase_pct),
    .done    (mul_done),
    .product (mul_product)
  );

  psls_serial_div #(
    .WIDTH (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_period_limit <= psls_pkg::RST_SLOW_LIMIT;
      pct_laser_off <= psls_pkg::RST_PCT_LASER_OFF;
      pct_line_start <= psls_pkg::RST_PCT_LINE_START;
      pct_line_end <= psls_pkg::RST_PCT_LINE_END;
      pct_sync_on <= psls_pkg::RST_PCT_SYNC_ON;
      pct_final <= psls_pkg::RST_PCT_FINAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psls_pkg::REG_SLOW_LIMIT: slow_period_limit <= cfg_data;
        psls_pkg::REG_PCT_LASER_OFF: pct_laser_off <= cfg_data[psls_pkg::PCT_W-1:0];
        psls_pkg::REG_PCT_LINE_START: pct_line_start <= cfg_data[psls_pkg::PCT_W-1:0];
        psls_pkg::REG_PCT_LINE_END: pct_line_end <= cfg_data[psls_pkg::PCT_W-1:0];
        psls_pkg::REG_PCT_SYNC_ON: pct_sync_on <= cfg_data[psls_pkg::PCT_W-1:0];
        psls_pkg::REG_PCT_FINAL: pct_final <= cfg_data[psls_pkg::PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan_phase <= '0;
      laser_forced_on <= 1'b1;
      last_period <= '0;
      swap_pending <= 1'b0;
      ring_pointer <= '0;
      ring_sum <= '0;
      average <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_accept) begin
            cur_period <= captured_period;
            cur_row_zero <= vertical_row_zero;
            work_time <= '0;
            work_load <= 1'b0;
            work_action <= psls_pkg::ACT_NONE;
            work_swap <= 1'b0;
            priority if (opcode == psls_pkg::OP_CAPTURE) begin
              ring_pointer <= ring_pointer_next;
              last_period <= captured_period;
              scan_phase <= '0;
              laser_forced_on <= (captured_period > slow_period_limit);
              state <= ST_READ;
            end else if (opcode == psls_pkg::OP_COMPARE) begin
              state <= ST_SEQ;
            end else if (opcode == psls_pkg::OP_SWAP) begin
              swap_pending <= 1'b1;
              state <= ST_DONE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          ring_sum <= ring_sum_next[SUM_W-1:0];
          state <= ST_AVG;
        end
        ST_AVG: begin
          if (div_done) begin
            average <= div_quotient[psls_pkg::PERIOD_W-1:0];
            state <= ST_SEQ;
          end
        end
        ST_SEQ: begin
          priority if (laser_forced_on) begin
            work_action <= psls_pkg::ACT_FORCE_ON;
            state <= ST_DONE;
          end else if (scan_phase > psls_pkg::PH_FINAL) begin
            state <= ST_DONE;
          end else begin
            work_action <= phase_action;
            if ((scan_phase == psls_pkg::PH_SYNC_ON) && swap_pending && cur_row_zero) begin
              work_swap <= 1'b1;
              swap_pending <= 1'b0;
            end
            scan_phase <= scan_phase + psls_pkg::PHASE_W'(1);
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_QUO;
          end
        end
        ST_QUO: begin
          if (div_done) begin
            work_time <= div_quotient[psls_pkg::PERIOD_W-1:0];
            work_load <= 1'b1;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            compare_time <= work_time;
            compare_load <= work_load;
            laser_action <= work_action;
            buffer_swap <= work_swap;
            filtered_period <= average;
            modulation_on <= ~laser_forced_on;
            res_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/psls_checker.sv
// Port-level checks for polygon_scan_line_sequencer and the bind that attaches
// them. Uses psls_pkg.
`default_nettype none

module psls_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           res_valid,
  input wire logic                           res_ready,
  input wire logic [psls_pkg::PERIOD_W-1:0]  compare_time,
  input wire logic                           compare_load,
  input wire logic [psls_pkg::ACT_W-1:0]     laser_action,
  input wire logic                           buffer_swap,
  input wire logic                           modulation_on
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(compare_time)
      && $stable(laser_action))
    else $error("result changed or dropped before its transfer");

  a_idle_time: assert property (@(posedge clk) disable iff (rst)
    res_valid && !compare_load |-> compare_time == '0)
    else $error("compare time without a load");

  a_forced: assert property (@(posedge clk) disable iff (rst)
    res_valid && laser_action == psls_pkg::ACT_FORCE_ON |-> !modulation_on && !compare_load)
    else $error("forced-on result with modulation or a compare load");

  a_swap_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && buffer_swap |-> laser_action == psls_pkg::ACT_LINE_END && compare_load)
    else $error("buffer swap outside line end");

endmodule

bind polygon_scan_line_sequencer psls_checker u_psls_checker (.*);

`default_nettype wire

>>> tb/sv/tb_polygon_scan_line_sequencer.sv
// Self-checking testbench for polygon_scan_line_sequencer. It sends capture, compare and
// swap commands with bursty traffic and a stalling receiver, and checks every result.
// Depends on psls_pkg and the polygon_scan_line_sequencer RTL.
`default_nettype none

module tb_polygon_scan_line_sequencer;
  import psls_pkg::*;

  localparam int DEPTH = FILTER_DEPTH_DEF;
  localparam int RING_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD = 500;
  localparam int TAIL_CYCLES = 70;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [PERIOD_W-1:0] period;
    logic                row_zero;
  } scan_cmd_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] cmp_time;
    logic                cmp_load;
    logic [ACT_W-1:0]    action;
    logic                swap;
    logic [PERIOD_W-1:0] avg;
    logic                mod_on;
  } scan_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  logic [OP_W-1:0] opcode = '0;
  logic [PERIOD_W-1:0] captured_period = '0;
  logic vertical_row_zero = 1'b0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [PERIOD_W-1:0] compare_time;
  logic compare_load;
  logic [ACT_W-1:0] laser_action;
  logic buffer_swap;
  logic [PERIOD_W-1:0] filtered_period;
  logic modulation_on;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  polygon_scan_line_sequencer dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .opcode(opcode),
    .captured_period(captured_period),
    .vertical_row_zero(vertical_row_zero),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .compare_time(compare_time),
    .compare_load(compare_load),
    .laser_action(laser_action),
    .buffer_swap(buffer_swap),
    .filtered_period(filtered_period),
    .modulation_on(modulation_on),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  scan_cmd_t pending_cmds[$];
  scan_result_t expected_results[$];
  int mismatch_count = 0;

  // Shadow copy of the sequencer state and its registers.
  logic [PERIOD_W-1:0] slow_limit_cfg;
  logic [PCT_W-1:0] pct_cfg [1:5];
  logic [PHASE_W-1:0] phase_q;
  logic forced_on;
  logic [PERIOD_W-1:0] line_period;
  logic swap_req;
  logic [PERIOD_W-1:0] period_ring [DEPTH];
  logic [RING_AW-1:0] ring_ptr;
  logic [PERIOD_W-1:0] avg_q;

  logic cmd_taken = 1'b0;
  int idle_cycles = 0;
  int gap_left = 0;
  int burst_left = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;
  int seg_left = 0;
  int rx_mode = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string field, input int unsigned got,
                               input int unsigned want);
    $display("mismatch in %s: got %0d, expected %0d", field, got, want);
    mismatch_count++;
  endtask

  task automatic predict_sequencer_result(input logic [OP_W-1:0] op,
                                          input logic [PERIOD_W-1:0] period,
                                          input logic row_zero);
    scan_result_t r;
    int ring_sum;
    logic [31:0] scaled;
    logic [PCT_W-1:0] pct;
    logic [ACT_W-1:0] act;
    logic step_ok;
    r = '0;
    pct = '0;
    act = ACT_NONE;
    if (op == OP_CAPTURE) begin
      ring_ptr = (ring_ptr == RING_AW'(DEPTH - 1)) ? '0 : ring_ptr + RING_AW'(1);
      period_ring[ring_ptr] = period;
      ring_sum = 0;
      foreach (period_ring[i]) ring_sum += int'(period_ring[i]);
      avg_q = PERIOD_W'(ring_sum / DEPTH);
      line_period = period;
      phase_q = PH_LASER_OFF;
      forced_on = (period > slow_limit_cfg);
    end
    if (op == OP_CAPTURE || op == OP_COMPARE) begin
      if (forced_on) begin
        r.action = ACT_FORCE_ON;
      end else begin
        step_ok = 1'b1;
        case (phase_q)
          PH_LASER_OFF: begin
            pct = pct_cfg[REG_PCT_LASER_OFF];
            act = ACT_NONE;
          end
          PH_LINE_START: begin
            pct = pct_cfg[REG_PCT_LINE_START];
            act = ACT_OFF;
          end
          PH_LINE_END: begin
            pct = pct_cfg[REG_PCT_LINE_END];
            act = ACT_LINE_START;
          end
          PH_SYNC_ON: begin
            pct = pct_cfg[REG_PCT_SYNC_ON];
            act = ACT_LINE_END;
          end
          PH_FINAL: begin
            pct = pct_cfg[REG_PCT_FINAL];
            act = ACT_SYNC_ON;
          end
          default: step_ok = 1'b0;
        endcase
        if (step_ok) begin
          scaled = 32'(line_period) * 32'(pct) / PCT_DIVISOR;
          r.cmp_time = scaled[PERIOD_W-1:0];
          r.cmp_load = 1'b1;
          r.action = act;
          if (phase_q == PH_SYNC_ON && swap_req && row_zero) begin
            r.swap = 1'b1;
            swap_req = 1'b0;
          end
          phase_q = phase_q + PHASE_W'(1);
        end
      end
    end else if (op == OP_SWAP) begin
      swap_req = 1'b1;
    end
    r.avg = avg_q;
    r.mod_on = !forced_on;
    expected_results.push_back(r);
  endtask

  // Result checking, prediction at each command transfer, and the watchdog.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      cmd_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      cmd_taken <= cmd_valid && cmd_ready;
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result transfer", 32'(laser_action), 0);
        end else begin
          want = expected_results.pop_front();
          if (compare_time !== want.cmp_time)
            note_mismatch("compare_time", 32'(compare_time), 32'(want.cmp_time));
          if (compare_load !== want.cmp_load)
            note_mismatch("compare_load", 32'(compare_load), 32'(want.cmp_load));
          if (laser_action !== want.action)
            note_mismatch("laser_action", 32'(laser_action), 32'(want.action));
          if (buffer_swap !== want.swap)
            note_mismatch("buffer_swap", 32'(buffer_swap), 32'(want.swap));
          if (filtered_period !== want.avg)
            note_mismatch("filtered_period", 32'(filtered_period), 32'(want.avg));
          if (modulation_on !== want.mod_on)
            note_mismatch("modulation_on", 32'(modulation_on), 32'(want.mod_on));
        end
      end
      if (cmd_valid && cmd_ready)
        predict_sequencer_result(opcode, captured_period, vertical_row_zero);
      if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Command driver: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    scan_cmd_t cur;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cur = pending_cmds.pop_front();
        opcode <= cur.op;
        captured_period <= cur.period;
        vertical_row_zero <= cur.row_zero;
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result receiver: segments of steady, random or sparse ready, plus one long hold.
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(10, 80);
        end
        seg_left--;
        case (rx_mode)
          0: res_ready <= 1'b1;
          1: res_ready <= 1'($urandom_range(0, 1));
          default: res_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [PERIOD_W-1:0] period,
                          input logic row_zero);
    pending_cmds.push_back('{op, period, row_zero});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_SLOW_LIMIT) slow_limit_cfg = data;
    else pct_cfg[idx] = data[PCT_W-1:0];
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 4))
      0: return PERIOD_W'($urandom);
      1: return slow_limit_cfg;
      2: return slow_limit_cfg + PERIOD_W'(1);
      3: return PERIOD_W'($urandom_range(0, 255));
      default: return PERIOD_W'($urandom_range(0, slow_limit_cfg));
    endcase
  endfunction

  // Mostly complete scan lines (capture, then compares with an optional swap request),
  // with some stray commands of any opcode mixed in.
  task automatic gen_traffic(input int n_items);
    int made;
    int n_cmp;
    int swap_at;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        push_cmd(OP_W'($urandom_range(0, 3)), PERIOD_W'($urandom),
                 1'($urandom_range(0, 1)));
        made++;
      end else begin
        n_cmp = $urandom_range(2, 7);
        swap_at = $urandom_range(0, 2 * n_cmp);
        push_cmd(OP_CAPTURE, pick_period(), 1'($urandom_range(0, 1)));
        for (int i = 0; i < n_cmp; i++) begin
          if (i == swap_at)
            push_cmd(OP_SWAP, PERIOD_W'($urandom), 1'($urandom_range(0, 1)));
          push_cmd(OP_COMPARE, PERIOD_W'($urandom), 1'($urandom_range(0, 1)));
        end
        made += n_cmp + 1 + ((swap_at < n_cmp) ? 1 : 0);
      end
    end
  endtask

  initial begin
    slow_limit_cfg = RST_SLOW_LIMIT;
    pct_cfg[REG_PCT_LASER_OFF] = RST_PCT_LASER_OFF;
    pct_cfg[REG_PCT_LINE_START] = RST_PCT_LINE_START;
    pct_cfg[REG_PCT_LINE_END] = RST_PCT_LINE_END;
    pct_cfg[REG_PCT_SYNC_ON] = RST_PCT_SYNC_ON;
    pct_cfg[REG_PCT_FINAL] = RST_PCT_FINAL;
    phase_q = PH_LASER_OFF;
    forced_on = 1'b1;
    line_period = '0;
    swap_req = 1'b0;
    period_ring = '{default: '0};
    ring_ptr = '0;
    avg_q = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings. The laser starts forced on, a zero period
    // enables modulation, the full period overflows the final compare time, and a line
    // runs past its last phase.
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_SWAP, 16'hFFFF, 1'b0);
    push_cmd(OP_UNUSED, 16'h1234, 1'b1);
    push_cmd(OP_CAPTURE, 16'h0000, 1'b0);
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_SWAP, 16'h0000, 1'b1);
    push_cmd(OP_CAPTURE, 16'hFFFF, 1'b0);
    push_cmd(OP_COMPARE, 16'hFFFF, 1'b0);
    push_cmd(OP_COMPARE, 16'hFFFF, 1'b0);
    push_cmd(OP_COMPARE, 16'hFFFF, 1'b0);
    push_cmd(OP_COMPARE, 16'hFFFF, 1'b0);
    push_cmd(OP_COMPARE, 16'hFFFF, 1'b0);
    push_cmd(OP_CAPTURE, 16'hAAAA, 1'b1);
    push_cmd(OP_CAPTURE, 16'h5555, 1'b0);
    push_cmd(OP_COMPARE, 16'h0000, 1'b0);
    push_cmd(OP_COMPARE, 16'h0000, 1'b0);
    push_cmd(OP_COMPARE, 16'h0000, 1'b1);
    push_cmd(OP_COMPARE, 16'h0000, 1'b0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_SLOW_LIMIT, 16'hFFFF);
          for (int r = REG_PCT_LASER_OFF; r <= REG_PCT_FINAL; r++)
            write_reg(CFG_IDX_W'(r), 16'h00FF);
        end
        1: begin
          write_reg(REG_SLOW_LIMIT, 16'h0000);
          for (int r = REG_PCT_LASER_OFF; r <= REG_PCT_FINAL; r++)
            write_reg(CFG_IDX_W'(r), 16'h0000);
        end
        5: begin
          write_reg(REG_SLOW_LIMIT, RST_SLOW_LIMIT);
          write_reg(REG_PCT_LASER_OFF, CFG_W'(RST_PCT_LASER_OFF));
          write_reg(REG_PCT_LINE_START, CFG_W'(RST_PCT_LINE_START));
          write_reg(REG_PCT_LINE_END, CFG_W'(RST_PCT_LINE_END));
          write_reg(REG_PCT_SYNC_ON, CFG_W'(RST_PCT_SYNC_ON));
          write_reg(REG_PCT_FINAL, CFG_W'(RST_PCT_FINAL));
        end
        default: begin
          write_reg(REG_SLOW_LIMIT, CFG_W'($urandom_range(0, 65535)));
          for (int r = REG_PCT_LASER_OFF; r <= REG_PCT_FINAL; r++)
            write_reg(CFG_IDX_W'(r), CFG_W'($urandom_range(0, 255)));
        end
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;
      if (ph == 2) long_hold_req = 1'b1;
      gen_traffic(75);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
